/* design/spv_pkg.sv */
package spv_pkg;

  // Fixed sizes of the block
  localparam int MAX_POINTS   = 32;
  localparam int PHASE_BITS   = 16;
  localparam int COORD_BITS   = 16;
  localparam int CNT_W        = 6;                  // point count register width
  localparam int K_W          = 6;                  // half-step index, 0..2N-1
  localparam int DIV_W        = K_W + PHASE_BITS;   // dividend width
  localparam int DVS_W        = CNT_W + 1;          // divisor 2N
  localparam int CORDIC_ITERS = 24;
  localparam int IT_W         = 5;
  localparam int XY_W         = 33;                 // Q30 rotation vector
  localparam int Z_W          = 32;                 // residual angle, 2^-32 turn
  localparam int RATIO_W      = 16;
  localparam int AXIS_W       = 15;
  localparam int FACT_W       = RATIO_W + AXIS_W;   // radius factor, Q15
  localparam int PROD_W       = 64;
  localparam int FRAC         = 46;
  localparam logic [XY_W-1:0] CORDIC_ONE = XY_W'(652032874);

  // Register map
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_STAR_MODE   = 2'd1;
  localparam logic [1:0] REG_INNER_RATIO = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]   point_count;
    logic               star_mode;
    logic [RATIO_W-1:0] inner_ratio;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV,
    ST_PREP,
    ST_ROT,
    ST_MUL,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic             item_load;
    logic             div_init;
    logic             div_step;
    logic             rot_init;
    logic             rot_step;
    logic             mul_en;
    logic             out_load;
    logic             last;
    logic [K_W-1:0]   k;
    logic [CNT_W-1:0] n;
    logic [IT_W-1:0]  iter;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
  } stat_t;

  // Arctangent of 2^-i in 2^-32 turn units
  function automatic logic [Z_W-1:0] atan_lut(logic [IT_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/star_polygon_vertex_generator_top.sv */
// Star / polygon vertex generator.
// Input channel (in_valid_i / in_stall_o): one transaction per shape, carrying
// the centre and the full width and height of the bounding ellipse.
// Output channel (out_valid_o / out_stall_i): one transaction per vertex in
// drawing order; is_inner_o marks inner star vertices, last_vertex_o the
// final vertex of the shape. N outer vertices, or 2N with star mode on.
// Configuration (point count, star mode, inner ratio) over the APB port at
// byte addresses 0, 4 and 8; write only while no shape is in flight.
// Each vertex passes through set-up, the bit-serial phase divider, a load,
// 24 CORDIC micro-rotations, a multiply and an output load. The input is
// stalled for the whole shape and taken again once the last vertex sits in
// the output register.
// A stalled receiver holds the output register; the engine waits at the
// output load until the register frees, so no vertex is lost.
// Reset returns to idle with the output empty and the registers at point
// count 5, star mode on, inner ratio 0.5.
module star_polygon_vertex_generator_top
  import spv_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic [AXIS_W-1:0]            ellipse_width_i,
  input  logic [AXIS_W-1:0]            ellipse_height_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] vertex_x_o,
  output logic signed [COORD_BITS-1:0] vertex_y_o,
  output logic                         is_inner_o,
  output logic                         last_vertex_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  spv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spv_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .center_x_i       (center_x_i),
    .center_y_i       (center_y_i),
    .ellipse_width_i  (ellipse_width_i),
    .ellipse_height_i (ellipse_height_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vertex_x_o       (vertex_x_o),
    .vertex_y_o       (vertex_y_o),
    .is_inner_o       (is_inner_o),
    .last_vertex_o    (last_vertex_o)
  );

endmodule

/* design/spv_cfg.sv */
module spv_cfg
  import spv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (paddr[3:2])
        REG_POINT_COUNT: cfg_d.point_count = pwdata[CNT_W-1:0];
        REG_STAR_MODE:   cfg_d.star_mode   = pwdata[0];
        REG_INNER_RATIO: cfg_d.inner_ratio = pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count <= CNT_W'(5);
      cfg_q.star_mode   <= 1'b1;
      cfg_q.inner_ratio <= RATIO_W'(16384);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_POINT_COUNT: prdata = 32'(cfg_q.point_count);
      REG_STAR_MODE:   prdata = 32'(cfg_q.star_mode);
      REG_INNER_RATIO: prdata = 32'(cfg_q.inner_ratio);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* design/spv_ctrl.sv */
module spv_ctrl
  import spv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e          state_q, state_d;
  logic [IT_W-1:0] cnt_q, cnt_d;
  logic [K_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0] n_eff;
  logic [K_W:0]    k_next;
  logic            last;
  logic            accept;

  // Clamp the point count to 3..MAX_POINTS
  always_comb begin
    if (cfg_i.point_count < CNT_W'(3))               n_eff = CNT_W'(3);
    else if (cfg_i.point_count > CNT_W'(MAX_POINTS)) n_eff = CNT_W'(MAX_POINTS);
    else                                             n_eff = cfg_i.point_count;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign k_next     = {1'b0, k_q} + (cfg_i.star_mode ? (K_W+1)'(1) : (K_W+1)'(2));
  assign last       = (k_next == {n_eff, 1'b0});

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        state_d = ST_INIT;
        k_d     = '0;
      end
      ST_INIT: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + IT_W'(1);
        if (cnt_q == IT_W'(DIV_W - 1)) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = ST_ROT;
        cnt_d   = '0;
      end
      ST_ROT: begin
        cnt_d = cnt_q + IT_W'(1);
        if (cnt_q == IT_W'(CORDIC_ITERS - 1)) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_EMIT;
      ST_EMIT: if (stat_i.slot_free) begin
        k_d     = k_next[K_W-1:0];
        state_d = last ? ST_IDLE : ST_INIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.k         = k_q;
    cmd_o.n         = n_eff;
    cmd_o.iter      = cnt_q;
    cmd_o.last      = last;
    cmd_o.item_load = accept;
    unique case (state_q)
      ST_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_PREP: cmd_o.rot_init = 1'b1;
      ST_ROT:  cmd_o.rot_step = 1'b1;
      ST_MUL:  cmd_o.mul_en   = 1'b1;
      ST_EMIT: cmd_o.out_load = stat_i.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

endmodule

/* design/spv_datapath.sv */
module spv_datapath
  import spv_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  cmd_t                         cmd_i,
  output stat_t                        stat_o,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic [AXIS_W-1:0]            ellipse_width_i,
  input  logic [AXIS_W-1:0]            ellipse_height_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] vertex_x_o,
  output logic signed [COORD_BITS-1:0] vertex_y_o,
  output logic                         is_inner_o,
  output logic                         last_vertex_o
);

  // Item registers
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic [AXIS_W-1:0]            w_q, h_q;
  logic [FACT_W-1:0]            rw_q, rh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      w_q  <= ellipse_width_i;
      h_q  <= ellipse_height_i;
      rw_q <= FACT_W'(cfg_i.inner_ratio) * FACT_W'(ellipse_width_i);
      rh_q <= FACT_W'(cfg_i.inner_ratio) * FACT_W'(ellipse_height_i);
    end
  end

  // Restoring divider: phase = (k*turn + N) / 2N, one bit a cycle
  logic [DIV_W-1:0] aq_q;
  logic [DVS_W:0]   rem_q, rem_sh, dvs;
  logic             ge;

  assign dvs    = {1'b0, cmd_i.n, 1'b0};
  assign rem_sh = {rem_q[DVS_W-1:0], aq_q[DIV_W-1]};
  assign ge     = (rem_sh >= dvs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      aq_q  <= {cmd_i.k, {PHASE_BITS{1'b0}}} + DIV_W'(cmd_i.n);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      aq_q  <= {aq_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_sh - dvs : rem_sh;
    end
  end

  // CORDIC rotation, one micro-rotation a cycle
  logic [PHASE_BITS-1:0]   phase;
  logic [1:0]              quad_q;
  logic signed [XY_W-1:0]  x_q, y_q, dx, dy;
  logic signed [Z_W-1:0]   z_q, at;

  assign phase = aq_q[PHASE_BITS-1:0] - PHASE_BITS'(1 << (PHASE_BITS - 2));
  assign dx    = y_q >>> cmd_i.iter;
  assign dy    = x_q >>> cmd_i.iter;
  assign at    = $signed(atan_lut(cmd_i.iter));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rot_init) begin
      quad_q <= phase[PHASE_BITS-1 -: 2];
      z_q    <= {2'b00, phase[PHASE_BITS-3:0], {(Z_W-PHASE_BITS){1'b0}}};
      x_q    <= CORDIC_ONE;
      y_q    <= '0;
    end else if (cmd_i.rot_step) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  // Quadrant fold and radius multiply
  logic signed [XY_W-1:0]      cos_v, sin_v;
  logic [FACT_W-1:0]           fx, fy;
  logic signed [FACT_W+XY_W:0] px, py;
  logic signed [PROD_W-1:0]    prod_x_q, prod_y_q;

  always_comb begin
    case (quad_q)
      2'd0:    begin cos_v = x_q;  sin_v = y_q;  end
      2'd1:    begin cos_v = -y_q; sin_v = x_q;  end
      2'd2:    begin cos_v = -x_q; sin_v = -y_q; end
      default: begin cos_v = y_q;  sin_v = -x_q; end
    endcase
  end

  // Outer radii carry the Q15 unity ratio so both kinds share one scale
  assign fx = cmd_i.k[0] ? rw_q : {w_q, {(RATIO_W-1){1'b0}}, 1'b0} >> 1;
  assign fy = cmd_i.k[0] ? rh_q : {h_q, {(RATIO_W-1){1'b0}}, 1'b0} >> 1;
  assign px = $signed({1'b0, fx}) * cos_v;
  assign py = $signed({1'b0, fy}) * sin_v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_x_q <= px[PROD_W-1:0];
      prod_y_q <= py[PROD_W-1:0];
    end
  end

  // Add centre, round half up, saturate
  function automatic logic [COORD_BITS-1:0] finish(logic signed [COORD_BITS-1:0] c,
                                                   logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0]          s;
    logic signed [PROD_W-FRAC-1:0]     r;
    s = (PROD_W'(c) <<< FRAC) + p + (PROD_W'(1) <<< (FRAC - 1));
    r = s[PROD_W-1:FRAC];
    if (r > $signed((PROD_W-FRAC)'((1 << (COORD_BITS - 1)) - 1)))
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    else if (r < -$signed((PROD_W-FRAC)'(1 << (COORD_BITS - 1))))
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    else
      return r[COORD_BITS-1:0];
  endfunction

  // Output register
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] vx_q, vy_q;
  logic                  inner_q, last_q;

  assign stat_o.slot_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      vx_q    <= finish(cx_q, prod_x_q);
      vy_q    <= finish(cy_q, prod_y_q);
      inner_q <= cmd_i.k[0];
      last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_x_o    = $signed(vx_q);
  assign vertex_y_o    = $signed(vy_q);
  assign is_inner_o    = inner_q;
  assign last_vertex_o = last_q;

endmodule

/* test/star_polygon_vertex_generator_top_tb.sv */
module star_polygon_vertex_generator_top_tb
  import spv_pkg::*;
();

  // Register addresses on the APB port
  localparam logic [PADDR_W-1:0] ADDR_POINT_COUNT = PADDR_W'({REG_POINT_COUNT, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_STAR_MODE   = PADDR_W'({REG_STAR_MODE, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_INNER_RATIO = PADDR_W'({REG_INNER_RATIO, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_UNUSED      = PADDR_W'(12);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         inner;
    logic                         last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_BITS-1:0] center_x_i = '0;
  logic signed [COORD_BITS-1:0] center_y_i = '0;
  logic [AXIS_W-1:0] ellipse_width_i = '0;
  logic [AXIS_W-1:0] ellipse_height_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [COORD_BITS-1:0] vertex_x_o;
  logic signed [COORD_BITS-1:0] vertex_y_o;
  logic is_inner_o;
  logic last_vertex_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the configuration
  logic [CNT_W-1:0]   shadow_count = 6'd5;
  logic               shadow_star = 1'b1;
  logic [RATIO_W-1:0] shadow_ratio = 16'd16384;

  vertex_t expected_vertices[$];
  int errors = 0;
  int stall_mode = 0;

  star_polygon_vertex_generator_top uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200000000;
    $display("star_polygon_vertex_generator_top regression: fail");
    $finish;
  end

  // Receiver stall pattern: mode picks no stalls, light, heavy or bursty
  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) == 0);
      2: out_stall_i <= ($urandom_range(0, 2) != 0);
      default: out_stall_i <= ($urandom_range(0, 31) < 16) ? out_stall_i : ~out_stall_i;
    endcase
  end

  function automatic longint fdiv(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-(v + 1)) >>> s) + 1);
  endfunction

  // Rotation-based cosine and sine of a 32-bit phase, Q30
  task automatic phase_to_cos_sin(input logic [31:0] ph, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = fdiv(y, i);
      dy = fdiv(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(IT_W'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(IT_W'(i)));
      end
    end
    case (ph[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic [COORD_BITS-1:0] round_sat(longint centre, longint offset, int frac);
    longint sum, r;
    sum = (centre <<< frac) + offset;
    r = fdiv(sum + (longint'(1) <<< (frac - 1)), frac);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[COORD_BITS-1:0];
  endfunction

  // Work out every vertex of one shape from the shadow configuration
  task automatic predict_shape(input logic signed [15:0] cx, input logic signed [15:0] cy,
                               input logic [14:0] w, input logic [14:0] h);
    int n, stride, total, cnt;
    longint ph, c, s, ox, oy;
    logic [31:0] ph32;
    vertex_t v;
    bit inner;
    int frac;
    n = shadow_count;
    if (n < 3) n = 3;
    if (n > MAX_POINTS) n = MAX_POINTS;
    stride = shadow_star ? 1 : 2;
    total = shadow_star ? 2 * n : n;
    cnt = 0;
    for (int k = 0; k < 2 * n; k += stride) begin
      ph = ((longint'(k) * 65536 + n) / (2 * n)) & 16'hFFFF;
      ph = (ph - 16384) & 16'hFFFF;
      ph32 = {ph[15:0], 16'h0000};
      phase_to_cos_sin(ph32, c, s);
      inner = k[0];
      if (inner) begin
        ox = longint'(shadow_ratio) * longint'(w) * c;
        oy = longint'(shadow_ratio) * longint'(h) * s;
        frac = 46;
      end else begin
        ox = longint'(w) * c;
        oy = longint'(h) * s;
        frac = 31;
      end
      v.x = round_sat(cx, ox, frac);
      v.y = round_sat(cy, oy, frac);
      v.inner = inner;
      v.last = (cnt + 1 == total);
      expected_vertices.push_back(v);
      cnt++;
    end
  endtask

  // Compare each accepted vertex with the oldest expectation
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d", vertex_x_o, vertex_y_o);
        errors++;
      end else begin
        e = expected_vertices.pop_front();
        if (vertex_x_o !== e.x) begin
          $error("vertex_x expected %0d actual %0d", e.x, vertex_x_o); errors++;
        end
        if (vertex_y_o !== e.y) begin
          $error("vertex_y expected %0d actual %0d", e.y, vertex_y_o); errors++;
        end
        if (is_inner_o !== e.inner) begin
          $error("is_inner expected %0b actual %0b", e.inner, is_inner_o); errors++;
        end
        if (last_vertex_o !== e.last) begin
          $error("last_vertex expected %0b actual %0b", e.last, last_vertex_o); errors++;
        end
      end
    end
  end

  // Send one shape request, predicting at the accepting edge
  task automatic send_shape(input logic signed [15:0] cx, input logic signed [15:0] cy,
                            input logic [14:0] w, input logic [14:0] h);
    center_x_i <= cx;
    center_y_i <= cy;
    ellipse_width_i <= w;
    ellipse_height_i <= h;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_shape(cx, cy, w, h);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain;
    while (expected_vertices.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (addr)
      ADDR_POINT_COUNT: shadow_count = data[CNT_W-1:0];
      ADDR_STAR_MODE:   shadow_star = data[0];
      ADDR_INNER_RATIO: shadow_ratio = data[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int n, input bit star, input int ratio);
    drain();
    apb_write(ADDR_POINT_COUNT, 32'(n));
    apb_write(ADDR_STAR_MODE, 32'(star));
    apb_write(ADDR_INNER_RATIO, 32'(ratio));
  endtask

  function automatic logic [14:0] random_axis;
    case ($urandom_range(0, 3))
      0: return 15'($urandom_range(0, 64));
      1: return 15'h7FFF - 15'($urandom_range(0, 3));
      default: return 15'($urandom);
    endcase
  endfunction

  // Extremes of centre and axes under the reset configuration
  task automatic test_reset_shapes;
    send_shape(16'sd0, 16'sd0, 15'd100, 15'd100);
    send_shape(16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h7FFF);
    send_shape(16'sh8000, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
    send_shape(-16'sd5, 16'sd7, 15'd0, 15'd0);
    send_shape(16'sd1000, -16'sd1000, 15'd0, 15'd3000);
  endtask

  // Clamped point counts, plain polygon, ratio above one, unknown address
  task automatic test_special_counts;
    configure(0, 1'b0, 0);
    send_shape(16'sd0, 16'sd0, 15'd2000, 15'd1000);
    configure(63, 1'b1, 65535);
    send_shape(16'sd100, 16'sd50, 15'd20000, 15'd30000);
    configure(2, 1'b1, 65535);
    send_shape(16'sh7000, -16'sh7000, 15'h7FFF, 15'h7FFF);
    configure(32, 1'b0, 32768);
    send_shape(-16'sd300, 16'sd300, 15'd4000, 15'd4000);
    configure(3, 1'b1, 0);
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_shape(16'sd1, -16'sd1, 15'd5555, 15'd7777);
  endtask

  // Random shapes in bursts under several settings and stall patterns
  task automatic test_random_shapes;
    int sent, burst;
    sent = 0;
    while (sent < 200) begin
      if (sent % 25 == 0) begin
        stall_mode = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
          0: configure($urandom_range(3, 8), $urandom_range(0, 1), $urandom);
          1: configure($urandom_range(0, 63), $urandom_range(0, 1), $urandom);
          2: configure(32, 1'b1, 16'hFFFF);
          default: configure(3, 1'b0, 0);
        endcase
      end
      burst = $urandom_range(1, 6);
      repeat (burst) begin
        send_shape(16'($urandom), 16'($urandom), random_axis(), random_axis());
        sent++;
      end
      if (sent == 100) drain();
      else repeat ($urandom_range(0, 40)) @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_shapes();
    test_special_counts();
    test_random_shapes();
    stall_mode = 0;
    drain();
    if (errors == 0 && expected_vertices.size() == 0) begin
      $display("star_polygon_vertex_generator_top regression: pass");
    end else begin
      $display("star_polygon_vertex_generator_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
design/spv_pkg.sv
design/spv_cfg.sv
design/spv_ctrl.sv
design/spv_datapath.sv
design/star_polygon_vertex_generator_top.sv
test/star_polygon_vertex_generator_top_tb.sv
